>>> rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS        = 4096;
  localparam int MAP_WORD_BITS     = 32;
  localparam int FIRST_ALLOC_BLOCK = 2;

  localparam int MAP_WORDS  = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(MAP_WORD_BITS);
  localparam int BLK_W      = 12;
  localparam int CNT_W      = 13;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  typedef logic [REQ_W-1:0]         req_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam req_t REQ_ALLOC = 2'd0;
  localparam req_t REQ_FREE  = 2'd1;
  localparam req_t REQ_QUERY = 2'd2;
  localparam req_t REQ_NOP   = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_SPACE  = 2'd1;
  localparam status_t ST_BAD_BLOCK = 2'd2;

endpackage

`default_nettype wire

>>> rtl/block_bitmap_allocator.sv
// Free, query and no-op requests load their map word into the read register, and the result
// goes to the output register once the output slot is free. Allocate reads one bitmap word
// per cycle from the single read port of the map memory until a hit or the last word in range.
// One request at a time; the next transfer in follows the cycle after the result is registered.
// Reset (synchronous, rst_n low): num_blocks 0, every map word reads as all in use via row
// valid bits, output register empty.
`default_nettype none

module block_bitmap_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bba_pkg::CNT_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bba_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [bba_pkg::BLK_W-1:0]     in_block_number,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bba_pkg::STATUS_W-1:0]       out_status,
  output logic [bba_pkg::BLK_W-1:0]          out_granted_block,
  output logic                               out_block_free
);

  localparam int WIW = bba_pkg::WORD_IDX_W;
  localparam int BIW = bba_pkg::BIT_IDX_W;
  localparam int WB  = bba_pkg::MAP_WORD_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [bba_pkg::CNT_W-1:0]    num_blocks_r;
  bba_pkg::req_t                req_r;
  logic [BIW-1:0]               bit_r;
  logic [WIW-1:0]               w_r, w_nxt;

  bba_pkg::map_word_t           mem [bba_pkg::MAP_WORDS];
  logic [bba_pkg::MAP_WORDS-1:0] row_valid_r;
  bba_pkg::map_word_t           rdata_r;
  logic                         rvld_r;

  logic                         rd_en, wr_en;
  logic [WIW-1:0]               rd_addr;
  bba_pkg::map_word_t           wr_data;

  logic                         out_valid_r;
  bba_pkg::status_t             out_status_r, status_nxt;
  logic [bba_pkg::BLK_W-1:0]    out_granted_r, granted_nxt;
  logic                         out_free_r, free_nxt;
  logic                         load_out;

  logic [bba_pkg::CNT_W-1:0]    lim, lim_m1;
  logic [WIW-1:0]               last_w;
  bba_pkg::map_word_t           word, avail, onehot, bit_sel;
  logic [BIW-1:0]               pos;
  logic                         hit, blk_in_range, slot_free, accept;

  assign in_stall          = (state_r != S_IDLE);
  assign accept            = in_valid && !in_stall;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_granted_r;
  assign out_block_free    = out_free_r;
  assign slot_free         = !out_valid_r || !out_stall;

  assign lim = (num_blocks_r > bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS)) ?
               bba_pkg::CNT_W'(bba_pkg::MAX_BLOCKS) : num_blocks_r;
  assign lim_m1 = lim - 1'b1;
  assign last_w = lim_m1[bba_pkg::BLK_W-1:BIW];

  // map word currently held in the read register; unwritten rows read as all in use
  assign word = rvld_r ? rdata_r : '0;
  assign blk_in_range = {1'b0, w_r, bit_r} < lim;
  assign bit_sel = bba_pkg::map_word_t'(1) << bit_r;

  always_comb begin
    logic [bba_pkg::BLK_W-1:0] b_v;
    avail = '0;
    for (int i = 0; i < WB; i++) begin
      b_v = {w_r, BIW'(i)};
      avail[i] = word[i] && (b_v >= bba_pkg::BLK_W'(bba_pkg::FIRST_ALLOC_BLOCK)) &&
                 ({1'b0, b_v} < lim);
    end
  end

  // isolate lowest free bit, then encode it
  assign onehot = avail & (~avail + 1'b1);
  assign hit    = |avail;

  always_comb begin
    pos = '0;
    for (int i = 0; i < WB; i++) begin
      pos = pos | (onehot[i] ? BIW'(i) : '0);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    w_nxt       = w_r;
    rd_en       = 1'b0;
    rd_addr     = w_r + 1'b1;
    wr_en       = 1'b0;
    wr_data     = word;
    load_out    = 1'b0;
    status_nxt  = bba_pkg::ST_OK;
    granted_nxt = '0;
    free_nxt    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_en = 1'b1;
          if (in_req_type == bba_pkg::REQ_ALLOC) begin
            rd_addr   = WIW'(bba_pkg::FIRST_ALLOC_BLOCK / bba_pkg::MAP_WORD_BITS);
            state_nxt = S_SCAN;
          end else begin
            rd_addr   = in_block_number[bba_pkg::BLK_W-1:BIW];
            state_nxt = S_EXEC;
          end
          w_nxt = rd_addr;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          if (req_r == bba_pkg::REQ_FREE) begin
            if (blk_in_range) begin
              wr_en   = 1'b1;
              wr_data = word | bit_sel;
            end else begin
              status_nxt = bba_pkg::ST_BAD_BLOCK;
            end
          end else if (req_r == bba_pkg::REQ_QUERY) begin
            free_nxt = blk_in_range && |(word & bit_sel);
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (slot_free) begin
            load_out    = 1'b1;
            wr_en       = 1'b1;
            wr_data     = word & ~onehot;
            granted_nxt = {w_r, pos};
            state_nxt   = S_IDLE;
          end
        end else if (lim <= bba_pkg::CNT_W'(bba_pkg::FIRST_ALLOC_BLOCK) || w_r >= last_w) begin
          if (slot_free) begin
            load_out   = 1'b1;
            status_nxt = bba_pkg::ST_NO_SPACE;
            state_nxt  = S_IDLE;
          end
        end else begin
          rd_en = 1'b1;
          w_nxt = rd_addr;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[w_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= row_valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[w_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_blocks_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        num_blocks_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (accept) begin
      req_r <= in_req_type;
      bit_r <= in_block_number[BIW-1:0];
    end
    if (load_out) begin
      out_status_r  <= status_nxt;
      out_granted_r <= granted_nxt;
      out_free_r    <= free_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bba_checker.sv
`default_nettype none

module bba_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [bba_pkg::STATUS_W-1:0]  out_status,
  input wire logic [bba_pkg::BLK_W-1:0]     out_granted_block,
  input wire logic                          out_block_free
);

  // one request in flight: input side closes right after a transfer in
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input transfer not followed by stall");

  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bba_pkg::ST_OK |-> out_granted_block == '0 && !out_block_free)
    else $error("failed request carries a grant or free flag");

  a_free_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_free |-> out_status == bba_pkg::ST_OK && out_granted_block == '0)
    else $error("query result mixed with allocate fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_block) && $stable(out_block_free))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_granted_block (out_granted_block),
  .out_block_free    (out_block_free)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    bba_pkg::status_t          status;
    logic [bba_pkg::BLK_W-1:0] granted;
    logic                      is_free;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [bba_pkg::MAX_BLOCKS-1:0] free_bits;
    logic [bba_pkg::CNT_W-1:0]    volume_blocks;
    alloc_result_t                expected_results[$];
    int                           errors;

    function new();
      free_bits     = '0;
      volume_blocks = '0;
      errors        = 0;
    endfunction

    function void set_volume(logic [bba_pkg::CNT_W-1:0] cnt);
      volume_blocks = cnt;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // predict the result of one accepted request and update the map copy
    function void note_request(bba_pkg::req_t req, logic [bba_pkg::BLK_W-1:0] blk);
      alloc_result_t want;
      int unsigned   lim;
      int unsigned   k;
      want = '{status: bba_pkg::ST_OK, granted: '0, is_free: 1'b0};
      // counts above the map size clamp to the map size
      lim = (volume_blocks > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : volume_blocks;
      case (req)
        bba_pkg::REQ_ALLOC: begin
          want.status = bba_pkg::ST_NO_SPACE;
          for (k = bba_pkg::FIRST_ALLOC_BLOCK; k < lim; k++) begin
            if (free_bits[k]) begin
              free_bits[k] = 1'b0;
              want.status  = bba_pkg::ST_OK;
              want.granted = bba_pkg::BLK_W'(k);
              break;
            end
          end
        end
        bba_pkg::REQ_FREE: begin
          if (blk < lim) free_bits[blk] = 1'b1;
          else want.status = bba_pkg::ST_BAD_BLOCK;
        end
        bba_pkg::REQ_QUERY: begin
          want.is_free = (blk < lim) && free_bits[blk];
        end
        default: ;
      endcase
      expected_results.push_back(want);
    endfunction

    function void check_result(bba_pkg::status_t st, logic [bba_pkg::BLK_W-1:0] granted,
                               logic is_free);
      alloc_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: status %0d granted %0d free %0d",
               st, granted, is_free);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, st);
        errors++;
      end
      if (granted !== want.granted) begin
        $error("granted_block: expected %0d, got %0d", want.granted, granted);
        errors++;
      end
      if (is_free !== want.is_free) begin
        $error("block_free: expected %0d, got %0d", want.is_free, is_free);
        errors++;
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 5000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [bba_pkg::CNT_W-1:0] cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  bba_pkg::req_t             in_req_type = bba_pkg::REQ_NOP;
  logic [bba_pkg::BLK_W-1:0] in_block_number = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  bba_pkg::status_t          out_status;
  logic [bba_pkg::BLK_W-1:0] out_granted_block;
  logic                      out_block_free;

  alloc_scoreboard sb;
  bit              steady = 1'b0;
  int              quiet_cycles = 0;

  block_bitmap_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_block_free    (out_block_free)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
  end

  // check before noting, so a result is never matched to the request accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_granted_block, out_block_free);
      if (in_valid && !in_stall)
        sb.note_request(in_req_type, in_block_number);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic issue_request(bba_pkg::req_t req, logic [bba_pkg::BLK_W-1:0] blk);
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_block_number <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_block_count(logic [bba_pkg::CNT_W-1:0] cnt);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cnt;
    @(posedge clk);
    sb.set_volume(cnt);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(logic [bba_pkg::CNT_W-1:0] cnt, int n_items, bit no_idle);
    int unsigned               lim;
    int unsigned               pick;
    logic [bba_pkg::BLK_W-1:0] blk;
    load_block_count(cnt);
    steady = no_idle;
    lim = (cnt > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : cnt;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (lim > 0 && $urandom_range(0, 9) != 0)
        blk = bba_pkg::BLK_W'($urandom_range(0, lim - 1));
      else blk = bba_pkg::BLK_W'($urandom);
      if (pick < 35)      issue_request(bba_pkg::REQ_ALLOC, bba_pkg::BLK_W'($urandom));
      else if (pick < 65) issue_request(bba_pkg::REQ_FREE, blk);
      else if (pick < 92) issue_request(bba_pkg::REQ_QUERY, blk);
      else                issue_request(bba_pkg::REQ_NOP, bba_pkg::BLK_W'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count still at its reset value: every block out of range
    issue_request(bba_pkg::REQ_ALLOC, 12'd0);
    issue_request(bba_pkg::REQ_FREE, 12'd0);
    issue_request(bba_pkg::REQ_QUERY, 12'd0);
    issue_request(bba_pkg::REQ_NOP, 12'd0);

    load_block_count(13'd4096);
    issue_request(bba_pkg::REQ_FREE, 12'd0);
    issue_request(bba_pkg::REQ_FREE, 12'd1);
    issue_request(bba_pkg::REQ_FREE, 12'd2);
    issue_request(bba_pkg::REQ_FREE, 12'd4095);
    issue_request(bba_pkg::REQ_FREE, 12'd4095);      // already free, stays free
    issue_request(bba_pkg::REQ_QUERY, 12'd4095);
    issue_request(bba_pkg::REQ_ALLOC, 12'd4095);
    issue_request(bba_pkg::REQ_ALLOC, 12'd0);        // scan runs to the top of the map
    issue_request(bba_pkg::REQ_ALLOC, 12'd0);        // blocks 0 and 1 free but never handed out
    issue_request(bba_pkg::REQ_QUERY, 12'd0);
    issue_request(bba_pkg::REQ_QUERY, 12'd4095);
    issue_request(bba_pkg::REQ_NOP, 12'd4095);

    load_block_count(13'd8191);                      // oversized count clamps to the map
    issue_request(bba_pkg::REQ_FREE, 12'd4095);
    issue_request(bba_pkg::REQ_QUERY, 12'd4095);

    load_block_count(13'd3);
    issue_request(bba_pkg::REQ_FREE, 12'd2);
    issue_request(bba_pkg::REQ_ALLOC, 12'd0);
    issue_request(bba_pkg::REQ_ALLOC, 12'd0);
    issue_request(bba_pkg::REQ_FREE, 12'd3);
    issue_request(bba_pkg::REQ_QUERY, 12'd4095);     // set in the map but out of range

    load_block_count(13'd2);
    issue_request(bba_pkg::REQ_FREE, 12'd1);
    issue_request(bba_pkg::REQ_ALLOC, 12'd0);

    random_phase(13'd4096, 400, 1'b0);
    random_phase(13'd40, 250, 1'b0);
    random_phase(13'd8191, 300, 1'b1);
    random_phase(bba_pkg::CNT_W'($urandom_range(0, 8191)), 250, 1'b0);
    random_phase(13'd0, 40, 1'b0);
    random_phase(13'd33, 200, 1'b0);
    random_phase(13'd4096, 250, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
